// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/clr_pkg.sv
// Types, codes and constants of the console line receiver.
`default_nettype none

package clr_pkg;

    localparam int LINE_SIZE_DEF = 64;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_ESCAPE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_DROP   = 2'd2;

    localparam logic [7:0]  ESCAPE_RST      = 8'h00;
    localparam logic [15:0] RAW_TIMEOUT_RST = 16'd1000;
    localparam logic [15:0] LINE_DROP_RST   = 16'd1000;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_MIN   = 8'h20;
    localparam logic [7:0] CHAR_LIMIT = 8'hF8;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    typedef enum logic [1:0] {
        OP_BYTE      = 2'd0,
        OP_TICK      = 2'd1,
        OP_ARM_COUNT = 2'd2,
        OP_ARM_ESC   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        KIND_RAW     = 2'd0,
        KIND_LINE    = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_DROP    = 2'd3
    } kind_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [7:0]  rx_byte;
        logic [15:0] raw_count;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  out_byte;
        logic        last;
        logic        crc_checked;
        logic [15:0] crc_value;
        logic        crc_match;
    } result_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic emit_line;
        logic needs_out;
        logic out_free;
        logic emit_last;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/clr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module clr_ram
    import clr_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = LINE_SIZE_DEF - 1
)
(
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/clr_ctrl.sv
// Controller: sequences item capture, execution and line readout.
`default_nettype none

module clr_ctrl
    import clr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  dp_status_t status,
    output ctrl_cmd_t  cmd
);

`include "assert_macros.svh"

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RD,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (status.emit_line)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_RD;
                end
                else if (!status.needs_out || status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            // line store read is in flight
            S_RD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = status.emit_last ? S_IDLE : S_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign item_ready = (state_reg == S_IDLE);

    `ASSERT_NEXT(a_capture_then_exec, cmd.capture, state_reg == S_EXEC, "capture not followed by exec")
    `ASSERT_IMPLY(a_emit_needs_slot, cmd.emit, status.out_free, "line item emitted into full slot")

endmodule

`default_nettype wire

// File: rtl/clr_dp.sv
// Datapath: mode and line state, CRC, tail parse, line store and result register.
`default_nettype none

module clr_dp
    import clr_pkg::*;
#(
    parameter int LINE_SIZE = LINE_SIZE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  item_t                item,
    output result_t              result,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  ctrl_cmd_t            cmd,
    output dp_status_t           status
);

`include "assert_macros.svh"

    localparam int LEN_W = $clog2(LINE_SIZE);
    localparam int DEPTH = LINE_SIZE - 1;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(DEPTH);
    localparam logic [LEN_W-1:0] TAIL_LEN = LEN_W'(4);

    localparam logic [7:0] CHAR_SP    = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_X_LO  = 8'h78;
    localparam logic [7:0] CHAR_X_UP  = 8'h58;
    localparam logic [7:0] CHAR_A_LO  = 8'h61;
    localparam logic [7:0] CHAR_F_LO  = 8'h66;
    localparam logic [7:0] CHAR_A_UP  = 8'h41;
    localparam logic [7:0] CHAR_F_UP  = 8'h46;

    typedef enum logic [1:0] {
        MODE_LINE  = 2'd0,
        MODE_COUNT = 2'd1,
        MODE_ESC   = 2'd2
    } mode_t;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    function automatic logic hex_ok(input logic [7:0] b);
        return (b >= CHAR_ZERO && b <= CHAR_NINE) || (b >= CHAR_A_LO && b <= CHAR_F_LO)
            || (b >= CHAR_A_UP && b <= CHAR_F_UP);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        if (b >= CHAR_ZERO && b <= CHAR_NINE)
            d = b - CHAR_ZERO;
        else if (b >= CHAR_A_LO && b <= CHAR_F_LO)
            d = b - CHAR_A_LO + 8'd10;
        else
            d = b - CHAR_A_UP + 8'd10;
        return d[3:0];
    endfunction

    // C-style base-16 parse of the four tail characters, compared with crc.
    // t[3] is the oldest character.
    function automatic logic tail_match(input logic [3:0][7:0] t, input logic [15:0] crc);
        logic [7:0]  p [4];
        logic [2:0]  pos;
        logic        stop;
        logic        neg;
        logic [15:0] v;
        for (int k = 0; k < 4; k++)
        begin
            p[k] = t[3-k];
        end
        pos  = 3'd0;
        stop = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (!stop && p[k] == CHAR_SP)
                pos = 3'(k + 1);
            else
                stop = 1'b1;
        end
        neg = 1'b0;
        if (pos < 3'd4 && (p[pos[1:0]] == CHAR_PLUS || p[pos[1:0]] == CHAR_MINUS))
        begin
            neg = (p[pos[1:0]] == CHAR_MINUS);
            pos = pos + 3'd1;
        end
        // prefix only taken when a hex digit follows it inside the four characters
        if (pos <= 3'd1 && p[pos[1:0]] == CHAR_ZERO
            && (p[pos[1:0] + 2'd1] == CHAR_X_LO || p[pos[1:0] + 2'd1] == CHAR_X_UP)
            && hex_ok(p[pos[1:0] + 2'd2]))
        begin
            pos = pos + 3'd2;
        end
        v    = 16'd0;
        stop = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            if (3'(k) >= pos && !stop)
            begin
                if (hex_ok(p[k]))
                    v = {v[11:0], hex_val(p[k])};
                else
                    stop = 1'b1;
            end
        end
        return neg ? (v == 16'd0 && crc == 16'd0) : (v == crc);
    endfunction

    logic [7:0]       escape_reg;
    logic [15:0]      raw_timeout_reg;
    logic [15:0]      line_drop_reg;
    mode_t            mode_reg, mode_next;
    logic [15:0]      bytes_left_reg, bytes_left_next;
    logic [15:0]      idle_reg, idle_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [15:0]      crc_reg, crc_next;
    logic [3:0][7:0]  tail_reg, tail_next;
    item_t            item_reg;
    logic [LEN_W-1:0] emit_len_reg, emit_len_next;
    logic             emit_chk_reg, emit_chk_next;
    logic [15:0]      emit_crc_reg, emit_crc_next;
    logic             emit_match_reg, emit_match_next;
    logic [LEN_W-1:0] idx_reg, idx_next;
    result_t          result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic [7:0]  c_map;
    logic        is_lf;
    logic        char_ok;
    logic [15:0] idle_inc;
    logic        timeout_hit;
    logic        drop_hit;
    logic        line_byte;
    logic        store_char;
    logic [15:0] bytes_dec;
    result_t     single_res;
    result_t     line_res;
    logic [7:0]  rd_data;

    assign c_map       = (item_reg.rx_byte == CHAR_CR) ? CHAR_LF : item_reg.rx_byte;
    assign is_lf       = (c_map == CHAR_LF);
    assign char_ok     = (c_map >= CHAR_MIN) && (c_map < CHAR_LIMIT);
    assign idle_inc    = (idle_reg == 16'hFFFF) ? idle_reg : idle_reg + 16'd1;
    assign timeout_hit = (idle_inc >= raw_timeout_reg);
    assign drop_hit    = (len_reg != '0) && (idle_inc >= line_drop_reg);
    assign line_byte   = (item_reg.opcode == OP_BYTE) && (mode_reg == MODE_LINE);
    assign store_char  = cmd.exec && line_byte && char_ok && (len_reg < LEN_MAX);
    assign bytes_dec   = (bytes_left_reg != 16'd0) ? bytes_left_reg - 16'd1 : bytes_left_reg;

    always_comb
    begin
        status.emit_line = line_byte && is_lf && (len_reg != '0);
        status.out_free  = !result_valid_reg || result_ready;
        status.emit_last = (idx_reg == emit_len_reg - LEN_W'(1));
        case (item_reg.opcode)
            OP_BYTE: status.needs_out = (mode_reg == MODE_COUNT) || (mode_reg == MODE_ESC);
            OP_TICK: status.needs_out = (mode_reg == MODE_ESC) ? timeout_hit : drop_hit;
            default: status.needs_out = 1'b0;
        endcase
    end

    always_comb
    begin
        single_res = '0;
        single_res.last = 1'b1;
        if (item_reg.opcode == OP_TICK)
        begin
            single_res.kind = (mode_reg == MODE_ESC) ? KIND_TIMEOUT : KIND_DROP;
        end
        else
        begin
            single_res.kind     = KIND_RAW;
            single_res.out_byte = item_reg.rx_byte;
            single_res.last     = (mode_reg == MODE_COUNT) ? (bytes_left_reg == 16'd1)
                                                           : (item_reg.rx_byte == escape_reg);
        end
    end

    always_comb
    begin
        line_res             = '0;
        line_res.kind        = KIND_LINE;
        line_res.out_byte    = rd_data;
        line_res.last        = status.emit_last;
        line_res.crc_checked = emit_chk_reg;
        line_res.crc_value   = emit_crc_reg;
        line_res.crc_match   = emit_match_reg;
    end

    always_comb
    begin
        mode_next       = mode_reg;
        bytes_left_next = bytes_left_reg;
        idle_next       = idle_reg;
        len_next        = len_reg;
        crc_next        = crc_reg;
        tail_next       = tail_reg;
        emit_len_next   = emit_len_reg;
        emit_chk_next   = emit_chk_reg;
        emit_crc_next   = emit_crc_reg;
        emit_match_next = emit_match_reg;
        idx_next        = idx_reg;

        if (cmd.exec)
        begin
            case (item_reg.opcode)
                OP_ARM_COUNT:
                begin
                    if (item_reg.raw_count != 16'd0)
                    begin
                        mode_next       = MODE_COUNT;
                        bytes_left_next = item_reg.raw_count;
                    end
                    else
                    begin
                        mode_next       = MODE_ESC;
                        bytes_left_next = 16'd0;
                    end
                end
                OP_ARM_ESC:
                begin
                    mode_next       = MODE_ESC;
                    bytes_left_next = 16'd0;
                end
                OP_TICK:
                begin
                    idle_next = idle_inc;
                    if (mode_reg == MODE_ESC)
                    begin
                        if (timeout_hit)
                            mode_next = MODE_LINE;
                    end
                    else if (drop_hit)
                    begin
                        len_next  = '0;
                        idle_next = 16'd0;
                        crc_next  = CRC_INIT;
                    end
                end
                default:
                begin
                    case (mode_reg)
                        MODE_COUNT:
                        begin
                            bytes_left_next = bytes_dec;
                            if (bytes_dec == 16'd0)
                                mode_next = MODE_LINE;
                        end
                        MODE_ESC:
                        begin
                            if (item_reg.rx_byte != escape_reg)
                                idle_next = 16'd0;
                            else
                                mode_next = MODE_LINE;
                        end
                        MODE_LINE:
                        begin
                            if (char_ok || is_lf)
                                idle_next = 16'd0;
                            if (store_char)
                            begin
                                len_next  = len_reg + LEN_W'(1);
                                tail_next = {tail_reg[2:0], c_map};
                                // CRC trails the stored line by four characters
                                if (len_reg >= TAIL_LEN)
                                    crc_next = crc_byte(crc_reg, tail_reg[3]);
                            end
                            if (is_lf)
                            begin
                                emit_len_next   = len_reg;
                                emit_chk_next   = (len_reg > TAIL_LEN);
                                emit_crc_next   = (len_reg > TAIL_LEN) ? crc_reg : 16'd0;
                                emit_match_next = (len_reg > TAIL_LEN)
                                                  && tail_match(tail_reg, crc_reg);
                                idx_next        = '0;
                                len_next        = '0;
                                crc_next        = CRC_INIT;
                            end
                        end
                        default:
                        begin
                            mode_next = mode_reg;
                        end
                    endcase
                end
            endcase
        end

        if (cmd.emit)
            idx_next = idx_reg + LEN_W'(1);
    end

    always_comb
    begin
        result_next       = result_reg;
        result_valid_next = result_valid_reg;
        if (cmd.emit)
        begin
            result_next       = line_res;
            result_valid_next = 1'b1;
        end
        else if (cmd.exec && status.needs_out)
        begin
            result_next       = single_res;
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            escape_reg       <= ESCAPE_RST;
            raw_timeout_reg  <= RAW_TIMEOUT_RST;
            line_drop_reg    <= LINE_DROP_RST;
            mode_reg         <= MODE_LINE;
            bytes_left_reg   <= 16'd0;
            idle_reg         <= 16'd0;
            len_reg          <= '0;
            crc_reg          <= CRC_INIT;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_ESCAPE:      escape_reg      <= cfg_data[7:0];
                    REG_RAW_TIMEOUT: raw_timeout_reg <= cfg_data;
                    REG_LINE_DROP:   line_drop_reg   <= cfg_data;
                    default:         escape_reg      <= escape_reg;
                endcase
            end
            mode_reg         <= mode_next;
            bytes_left_reg   <= bytes_left_next;
            idle_reg         <= idle_next;
            len_reg          <= len_next;
            crc_reg          <= crc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            item_reg <= item;
        tail_reg       <= tail_next;
        emit_len_reg   <= emit_len_next;
        emit_chk_reg   <= emit_chk_next;
        emit_crc_reg   <= emit_crc_next;
        emit_match_reg <= emit_match_next;
        idx_reg        <= idx_next;
        result_reg     <= result_next;
    end

    clr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk     (clk),
        .wr_en   (store_char),
        .wr_addr (len_reg[AW-1:0]),
        .wr_data (c_map),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    `ASSERT_ALWAYS(a_len_range, len_reg <= LEN_MAX, "line length beyond store depth")
    `ASSERT_IMPLY(a_count_nonzero, mode_reg == MODE_COUNT, bytes_left_reg != 16'd0, "counted mode with nothing left")

endmodule

`default_nettype wire

// File: rtl/console_line_receiver.sv
// An item is accepted only when idle, captured into the item register and executed,
// and any result is registered once the output slot is free. A line end emits its stored
// characters one by one, paced by the line store's single registered read port.
// Reset (rst_n, async, active low) clears mode, counters, line length and output valid
// and restores the configuration registers; the line store contents are left as they are.
`default_nettype none

module console_line_receiver
    import clr_pkg::*;
#(
    parameter int LINE_SIZE = LINE_SIZE_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 item_valid,
    output logic                 item_ready,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_ready,
    output result_t              result
);

    ctrl_cmd_t  cmd;
    dp_status_t status;

    clr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .status     (status),
        .cmd        (cmd)
    );

    clr_dp #(
        .LINE_SIZE (LINE_SIZE)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .result       (result),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

`default_nettype wire
